[rtl/pica_pkg.sv]
// Package for the PI controller with back-calculation anti-windup.
// Holds widths, constants, register indexes, sequencer states and the control
// and configuration structs shared by all files. No dependencies.
package pica_pkg;

  localparam int unsigned DataW   = 16;
  localparam int unsigned AccW    = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PShift  = 4;
  localparam int unsigned OutShift = 15;

  // Error limits used in clamp mode.
  localparam logic signed [DataW-1:0] ErrHi = 16'sd255;
  localparam logic signed [DataW-1:0] ErrLo = -16'sd255;

  // Reset values of the output limits.
  localparam logic signed [DataW-1:0] OutMaxRst = 16'sh7fff;
  localparam logic signed [DataW-1:0] OutMinRst = 16'sh8000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KP      = 3'd0,
    REG_KI      = 3'd1,
    REG_KC      = 3'd2,
    REG_OUT_MAX = 3'd3,
    REG_OUT_MIN = 3'd4,
    REG_CLAMP   = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROP,
    S_RAW,
    S_INT,
    S_FIN
  } pica_state_e;

  typedef enum logic [1:0] {
    MUL_KP,
    MUL_KI,
    MUL_KC
  } mul_sel_e;

  typedef enum logic [1:0] {
    ADD_RAW,
    ADD_INC,
    ADD_DEC
  } add_sel_e;

  typedef struct packed {
    logic     load_err;
    logic     prod_en;
    mul_sel_e mul_sel;
    add_sel_e add_sel;
    logic     load_out;
    logic     integ_en;
  } pica_ctrl_t;

  typedef struct packed {
    logic signed [DataW-1:0] kp;
    logic signed [DataW-1:0] ki;
    logic signed [DataW-1:0] kc;
    logic signed [DataW-1:0] out_max;
    logic signed [DataW-1:0] out_min;
    logic                    clamp_error;
  } pica_cfg_t;

endpackage

[rtl/pica_in_if.sv]
// Input channel of the PI controller: valid, ready and the sample pair.
// Depends on pica_pkg for the data width.
interface pica_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [pica_pkg::DataW-1:0] reference;
  logic signed [pica_pkg::DataW-1:0] measured;

  modport source (output valid, output reference, output measured, input ready);
  modport sink   (input valid, input reference, input measured, output ready);
endinterface

[rtl/pica_out_if.sv]
// Output channel of the PI controller: valid, ready and the drive value.
// Depends on pica_pkg for the data width.
interface pica_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pica_pkg::DataW-1:0] drive_out;

  modport source (output valid, output drive_out, input ready);
  modport sink   (input valid, input drive_out, output ready);
endinterface

[rtl/pica_seq.sv]
// Sequencer of the PI controller: steps the shared multiplier and adder
// through one sample and tracks the output register. Depends on pica_pkg.
module pica_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output pica_pkg::pica_ctrl_t ctrl_o
);

  pica_pkg::pica_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_blocked;

  // A result is still waiting and will not leave this cycle.
  assign out_blocked = out_valid_q && !out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pica_pkg::S_IDLE: if (in_valid_i) state_d = pica_pkg::S_PROP;
      pica_pkg::S_PROP: state_d = pica_pkg::S_RAW;
      pica_pkg::S_RAW:  if (!out_blocked) state_d = pica_pkg::S_INT;
      pica_pkg::S_INT:  state_d = pica_pkg::S_FIN;
      pica_pkg::S_FIN:  state_d = pica_pkg::S_IDLE;
      default:          state_d = pica_pkg::S_IDLE;
    endcase
  end

  // Control outputs for the datapath.
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.mul_sel  = pica_pkg::MUL_KP;
    ctrl_o.add_sel  = pica_pkg::ADD_RAW;
    in_ready_o      = 1'b0;
    case (state_q)
      pica_pkg::S_IDLE: begin
        in_ready_o      = 1'b1;
        ctrl_o.load_err = in_valid_i;
      end
      pica_pkg::S_PROP: begin
        ctrl_o.mul_sel = pica_pkg::MUL_KP;
        ctrl_o.prod_en = 1'b1;
      end
      pica_pkg::S_RAW: begin
        // Raw output and the integral product are formed together.
        ctrl_o.mul_sel  = pica_pkg::MUL_KI;
        ctrl_o.add_sel  = pica_pkg::ADD_RAW;
        ctrl_o.prod_en  = !out_blocked;
        ctrl_o.load_out = !out_blocked;
      end
      pica_pkg::S_INT: begin
        ctrl_o.mul_sel  = pica_pkg::MUL_KC;
        ctrl_o.prod_en  = 1'b1;
        ctrl_o.add_sel  = pica_pkg::ADD_INC;
        ctrl_o.integ_en = 1'b1;
      end
      pica_pkg::S_FIN: begin
        ctrl_o.add_sel  = pica_pkg::ADD_DEC;
        ctrl_o.integ_en = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Output valid: set when a drive value is loaded, cleared on its transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pica_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/pica_datapath.sv]
// Datapath of the PI controller: error limiter, one shared 16x16 multiplier,
// one shared 32-bit adder, output clamp and the integrator. Depends on pica_pkg.
module pica_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pica_pkg::pica_ctrl_t              ctrl_i,
  input  pica_pkg::pica_cfg_t               cfg_i,
  input  logic signed [pica_pkg::DataW-1:0] reference_i,
  input  logic signed [pica_pkg::DataW-1:0] measured_i,
  output logic signed [pica_pkg::DataW-1:0] drive_o
);

  logic signed [pica_pkg::DataW-1:0] diff, err_d, err_q;
  logic signed [pica_pkg::DataW-1:0] mul_a, mul_b;
  logic signed [pica_pkg::AccW-1:0]  mul_a_ext, mul_b_ext, prod_d, prod_q;
  logic        [pica_pkg::AccW-1:0]  add_a, add_b, sum;
  logic                              add_sub;
  logic signed [pica_pkg::DataW-1:0] raw, drv, exc_d, exc_q, drive_q;
  logic        [pica_pkg::AccW-1:0]  integ_q;

  // Error wraps to 16 bits, then is limited in clamp mode.
  always_comb begin
    diff  = reference_i - measured_i;
    err_d = diff;
    if (cfg_i.clamp_error) begin
      if (diff > pica_pkg::ErrHi) begin
        err_d = pica_pkg::ErrHi;
      end else if (diff < pica_pkg::ErrLo) begin
        err_d = pica_pkg::ErrLo;
      end
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (ctrl_i.mul_sel)
      pica_pkg::MUL_KP: begin
        mul_a = err_q;
        mul_b = cfg_i.kp;
      end
      pica_pkg::MUL_KI: begin
        mul_a = err_q;
        mul_b = cfg_i.ki;
      end
      pica_pkg::MUL_KC: begin
        mul_a = exc_q;
        mul_b = cfg_i.kc;
      end
      default: begin
        mul_a = err_q;
        mul_b = cfg_i.kp;
      end
    endcase
  end

  assign mul_a_ext = pica_pkg::AccW'(mul_a);
  assign mul_b_ext = pica_pkg::AccW'(mul_b);
  assign prod_d    = mul_a_ext * mul_b_ext;

  // Shared adder: raw accumulation, then the two integrator updates.
  always_comb begin
    case (ctrl_i.add_sel)
      pica_pkg::ADD_RAW: begin
        add_a   = prod_q << pica_pkg::PShift;
        add_b   = integ_q;
        add_sub = 1'b0;
      end
      pica_pkg::ADD_INC: begin
        add_a   = integ_q;
        add_b   = prod_q;
        add_sub = 1'b0;
      end
      pica_pkg::ADD_DEC: begin
        add_a   = integ_q;
        add_b   = prod_q;
        add_sub = 1'b1;
      end
      default: begin
        add_a   = integ_q;
        add_b   = prod_q;
        add_sub = 1'b0;
      end
    endcase
    sum = add_a + (add_b ^ {pica_pkg::AccW{add_sub}}) + pica_pkg::AccW'(add_sub);
  end

  // Output clamp, upper limit first; inverted limits give max above it, else min.
  always_comb begin
    raw = sum[pica_pkg::OutShift +: pica_pkg::DataW];
    if (raw > cfg_i.out_max) begin
      drv = cfg_i.out_max;
    end else if (raw < cfg_i.out_min) begin
      drv = cfg_i.out_min;
    end else begin
      drv = raw;
    end
    exc_d = raw - drv;
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_err) begin
      err_q <= err_d;
    end
    if (ctrl_i.prod_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.load_out) begin
      drive_q <= drv;
      exc_q   <= exc_d;
    end
  end

  // Integrator, cleared by reset and wrapping modulo 2^32.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (ctrl_i.integ_en) begin
      integ_q <= sum;
    end
  end

  assign drive_o = drive_q;

endmodule

[rtl/pi_controller_antiwindup_top.sv]
// PI controller with back-calculation anti-windup, top level.
// After an input transfer the sequencer steps through S_PROP and S_RAW, where the
// drive value is registered. One sample at a time is taken: the single shared
// multiplier and adder go through the proportional, integral and anti-windup terms.
// The raw-output step waits while an earlier drive value has not been taken.
// Reset clears the integrator and loads the register reset values; no clearing pass.
module pi_controller_antiwindup_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  pica_in_if.sink                             in_if,
  pica_out_if.source                          out_if,
  input  logic                                cfg_we_i,
  input  logic [pica_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [pica_pkg::DataW-1:0]          cfg_wdata_i
);

  pica_pkg::pica_cfg_t  cfg_q;
  pica_pkg::pica_ctrl_t ctrl;
  logic                 in_ready;
  logic                 out_valid;

  // Configuration registers; writes to unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kp          <= '0;
      cfg_q.ki          <= '0;
      cfg_q.kc          <= '0;
      cfg_q.out_max     <= pica_pkg::OutMaxRst;
      cfg_q.out_min     <= pica_pkg::OutMinRst;
      cfg_q.clamp_error <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pica_pkg::REG_KP:      cfg_q.kp          <= cfg_wdata_i;
        pica_pkg::REG_KI:      cfg_q.ki          <= cfg_wdata_i;
        pica_pkg::REG_KC:      cfg_q.kc          <= cfg_wdata_i;
        pica_pkg::REG_OUT_MAX: cfg_q.out_max     <= cfg_wdata_i;
        pica_pkg::REG_OUT_MIN: cfg_q.out_min     <= cfg_wdata_i;
        pica_pkg::REG_CLAMP:   cfg_q.clamp_error <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  pica_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_valid),
    .ctrl_o      (ctrl)
  );

  pica_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg_q),
    .reference_i (in_if.reference),
    .measured_i  (in_if.measured),
    .drive_o     (out_if.drive_out)
  );

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

  // The block is busy in the cycle after an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_ready) |=> !in_ready)
    else $error("input accepted while a sample is in progress");

  // A new drive value never overwrites one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load_out |-> !(out_valid && !out_if.ready))
    else $error("pending drive value overwritten");

  // The integrator only moves while a sample is being processed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.integ_en |-> !in_ready)
    else $error("integrator updated while idle");

  // A drive value is loaded in S_RAW, after S_PROP follows an input transfer,
  // whenever the output side was free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_ready) |=> ##1 (ctrl.load_out || (out_valid && !out_if.ready)))
    else $error("drive value not produced on schedule");

endmodule
